[design/latency_stats_top_k_defines.svh]
// assertion helpers for the latency statistics block
`ifndef LATENCY_STATS_TOP_K_DEFINES_SVH
`define LATENCY_STATS_TOP_K_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LST_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("latency_stats_top_k check failed");

// next-cycle implication, checked outside reset
`define LST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("latency_stats_top_k check failed");

`endif

[design/lst_pkg.sv]
package lst_pkg;

    localparam int TIME_W       = 32;
    localparam int TAG_IN_W     = 16;
    localparam int COUNT_W      = 32;
    localparam int TOTAL_W      = 64;
    localparam int OUT_RANKS    = 3;
    localparam int DEF_TOP_K    = 3;
    localparam int DEF_TAG_BITS = 16;
    localparam int DIV_STEPS    = TOTAL_W;
    localparam int IN_DATA_W    = TIME_W + TAG_IN_W;
    localparam int OUT_DATA_W   = COUNT_W + TOTAL_W + TIME_W
                                + OUT_RANKS * (TIME_W + TAG_IN_W);

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

[design/latency_stats_top_k.sv]
// latency_stats_top_k: running count, total and mean of processing-time
// samples, plus a descending list of the TOP_K largest times with their tags.
// input item on s_axis: sample time and source tag. every input item gives
// exactly one output item on m_axis with count, total, truncated mean and
// the three highest ranks (time and tag, zero where a rank is empty).
// count and total saturate; the mean saturates at all ones.
// an accepted item passes the load, divide and wait states of the sequencer
// before it is written to the output register; the mean comes from a
// radix-2 divider that retires one quotient bit per cycle, so one item is in
// work at a time and s_axis_tready is low until the divider is done and the
// result sits in the output register.
// the output register holds a finished item while the next one is taken in;
// if the receiver stalls, the following item waits after its division until
// the output register frees up.
// reset clears count, total, the rank list, the output valid flag and the
// sequencer; the block is ready from the first cycle after reset is released.
`include "latency_stats_top_k_defines.svh"

module latency_stats_top_k
    import lst_pkg::*;
#(
    parameter int TOP_K    = DEF_TOP_K,
    parameter int TAG_BITS = DEF_TAG_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // sample_time[31:0], source_tag[47:32]
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // sample_count[31:0], time_total[95:32], mean_time[127:96],
    // rank0_time[159:128], rank1_time[191:160], rank2_time[223:192],
    // rank0_tag[239:224], rank1_tag[255:240], rank2_tag[271:256]
    output logic [OUT_DATA_W-1:0]  m_axis_tdata
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOAD = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_WAIT = 2'd3;

    logic [1:0]                      state_reg, state_next;
    logic [COUNT_W-1:0]              count_reg, count_next;
    logic [TOTAL_W-1:0]              total_reg, total_next;
    logic [TOTAL_W:0]                total_sum;
    logic                            out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0]           out_data_reg;
    logic                            in_fire;
    logic                            out_load;
    logic [TIME_W-1:0]               in_time;
    logic [TAG_IN_W-1:0]             in_tag;
    logic [31:0]                     in_tag_wide;
    logic [TAG_BITS-1:0]             in_tag_kept;
    div_stat_t                       div_stat;
    logic [TOTAL_W-1:0]              quotient;
    logic [TIME_W-1:0]               mean_sat;
    logic [TOP_K-1:0][TIME_W-1:0]    rank_times;
    logic [TOP_K-1:0][TAG_BITS-1:0]  rank_tags;
    logic [OUT_RANKS-1:0][TIME_W-1:0]   out_times;
    logic [OUT_RANKS-1:0][TAG_IN_W-1:0] out_tags;

    assign in_time     = s_axis_tdata[TIME_W-1:0];
    assign in_tag      = s_axis_tdata[IN_DATA_W-1:TIME_W];
    assign in_tag_wide = 32'(in_tag);
    assign in_tag_kept = in_tag_wide[TAG_BITS-1:0];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_load      = (state_reg == S_WAIT) && (!out_valid_reg || m_axis_tready);

    assign total_sum = {1'b0, total_reg} + (TOTAL_W + 1)'(in_time);

    always_comb
    begin
        count_next = count_reg;
        total_next = total_reg;
        if (in_fire)
        begin
            if (count_reg != '1)
            begin
                count_next = count_reg + 1'b1;
            end
            total_next = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    lst_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_LOAD),
        .dividend (total_reg),
        .divisor  (count_reg),
        .stat     (div_stat),
        .quotient (quotient)
    );

    lst_rank
    #(
        .TOP_K    (TOP_K),
        .TAG_BITS (TAG_BITS)
    )
    u_rank
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .update      (in_fire),
        .sample_time (in_time),
        .sample_tag  (in_tag_kept),
        .rank_times  (rank_times),
        .rank_tags   (rank_tags)
    );

    assign mean_sat = (quotient[TOTAL_W-1:TIME_W] != '0) ? '1 : quotient[TIME_W-1:0];

    for (genvar r = 0; r < OUT_RANKS; r++)
    begin : g_rank_out
        if (r < TOP_K)
        begin : g_kept
            logic [31:0] tag_wide;
            assign tag_wide     = 32'(rank_tags[r]);
            assign out_times[r] = rank_times[r];
            assign out_tags[r]  = tag_wide[TAG_IN_W-1:0];
        end
        else
        begin : g_empty
            assign out_times[r] = '0;
            assign out_tags[r]  = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= {out_tags[2], out_tags[1], out_tags[0],
                             out_times[2], out_times[1], out_times[0],
                             mean_sat, total_reg, count_reg};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `LST_ASSERT_IMPL(a_ready_idle_div, s_axis_tready, !div_stat.busy)
    `LST_ASSERT_NEXT(a_accept_blocks, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `LST_ASSERT_IMPL(a_out_from_wait, $rose(m_axis_tvalid), $past(state_reg) == S_WAIT)
    `LST_ASSERT_NEXT(a_count_monotonic, 1'b1, count_reg >= $past(count_reg))

endmodule

[design/lst_div.sv]
module lst_div
    import lst_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [TOTAL_W-1:0]   dividend,
    input  logic [COUNT_W-1:0]   divisor,
    output div_stat_t            stat,
    output logic [TOTAL_W-1:0]   quotient
);

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [COUNT_W-1:0]   rem_reg, rem_next;
    logic [TOTAL_W-1:0]   quo_reg, quo_next;
    logic [COUNT_W-1:0]   dsr_reg, dsr_next;
    logic [COUNT_W+1:0]   diff;
    logic                 fits;

    // one restoring step per cycle, dividend shifts out as quotient shifts in
    assign diff = {1'b0, rem_reg, quo_reg[TOTAL_W-1]} - {2'b00, dsr_reg};
    assign fits = ~diff[COUNT_W+1];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_STEPS - 1);
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = diff[COUNT_W-1:0];
            end
            else
            begin
                rem_next = {rem_reg[COUNT_W-2:0], quo_reg[TOTAL_W-1]};
            end
            quo_next = {quo_reg[TOTAL_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

[design/lst_rank.sv]
module lst_rank
    import lst_pkg::*;
#(
    parameter int TOP_K    = DEF_TOP_K,
    parameter int TAG_BITS = DEF_TAG_BITS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              update,
    input  logic [TIME_W-1:0]                 sample_time,
    input  logic [TAG_BITS-1:0]               sample_tag,
    output logic [TOP_K-1:0][TIME_W-1:0]      rank_times,
    output logic [TOP_K-1:0][TAG_BITS-1:0]    rank_tags
);

    logic [TOP_K-1:0][TIME_W-1:0]   times_reg, times_next;
    logic [TOP_K-1:0][TAG_BITS-1:0] tags_reg, tags_next;
    logic [TOP_K-1:0]               above;

    // list is descending, so the entries the new time beats form a tail
    always_comb
    begin
        for (int i = 0; i < TOP_K; i++)
        begin
            above[i] = sample_time > times_reg[i];
        end
        times_next = times_reg;
        tags_next  = tags_reg;
        for (int i = 0; i < TOP_K; i++)
        begin
            if (above[i])
            begin
                if (i == 0)
                begin
                    times_next[i] = sample_time;
                    tags_next[i]  = sample_tag;
                end
                else if (!above[i-1])
                begin
                    times_next[i] = sample_time;
                    tags_next[i]  = sample_tag;
                end
                else
                begin
                    times_next[i] = times_reg[i-1];
                    tags_next[i]  = tags_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            times_reg <= '0;
            tags_reg  <= '0;
        end
        else if (update)
        begin
            times_reg <= times_next;
            tags_reg  <= tags_next;
        end
    end

    assign rank_times = times_reg;
    assign rank_tags  = tags_reg;

endmodule

[verif/tb_latency_stats_top_k.sv]
module tb_latency_stats_top_k;
    timeunit 1ns;
    timeprecision 1ps;

    import lst_pkg::*;

    typedef struct packed {
        logic [TAG_IN_W-1:0] source_tag;
        logic [TIME_W-1:0]   sample_time;
    } sample_in_t;

    typedef struct packed {
        logic [TAG_IN_W-1:0] rank2_tag;
        logic [TAG_IN_W-1:0] rank1_tag;
        logic [TAG_IN_W-1:0] rank0_tag;
        logic [TIME_W-1:0]   rank2_time;
        logic [TIME_W-1:0]   rank1_time;
        logic [TIME_W-1:0]   rank0_time;
        logic [TIME_W-1:0]   mean_time;
        logic [TOTAL_W-1:0]  time_total;
        logic [COUNT_W-1:0]  sample_count;
    } stats_t;

    typedef struct {
        logic [TIME_W-1:0]   sample_time;
        logic [TAG_IN_W-1:0] source_tag;
        bit                  typed;
        stats_t              want;
    } probe_row_t;

    typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} idle_mode_t;

    localparam int NUM_PROBES   = 14;
    localparam int NUM_RANDOM   = 950;
    localparam int MODE_ITEMS   = 120;
    localparam int DRAIN_CYCLES = 100;
    localparam int MAX_PRINTS   = 40;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;

    logic [COUNT_W-1:0]     seen_count = '0;
    logic [TOTAL_W-1:0]     time_sum = '0;
    logic [TIME_W-1:0]      kept_time [DEF_TOP_K];
    logic [31:0]            kept_tag [DEF_TOP_K];

    stats_t                 expected_stats [$];
    int                     mismatch_count = 0;
    idle_mode_t             idle_mode = IDLE_LIGHT;
    int                     burst_left = 0;
    int                     ready_hold = 0;

    probe_row_t probe_rows [NUM_PROBES] = '{
        '{32'h0000_0000, 16'h1234, 1'b1,
          '{sample_count: 32'd1, time_total: 64'd0, mean_time: 32'd0, default: '0}},
        '{32'hFFFF_FFFF, 16'hFFFF, 1'b1,
          '{sample_count: 32'd2, time_total: 64'h0000_0000_FFFF_FFFF,
            mean_time: 32'h7FFF_FFFF, rank0_time: 32'hFFFF_FFFF, rank0_tag: 16'hFFFF,
            default: '0}},
        '{32'h0000_0001, 16'h0001, 1'b1,
          '{sample_count: 32'd3, time_total: 64'h0000_0001_0000_0000,
            mean_time: 32'h5555_5555, rank0_time: 32'hFFFF_FFFF, rank0_tag: 16'hFFFF,
            rank1_time: 32'd1, rank1_tag: 16'h0001, default: '0}},
        '{32'h8000_0000, 16'hAAAA, 1'b0, '0},
        '{32'h8000_0000, 16'h5555, 1'b0, '0},
        '{32'h8000_0000, 16'h0F0F, 1'b0, '0},
        '{32'h8000_0001, 16'hF0F0, 1'b0, '0},
        '{32'hFFFF_FFFF, 16'h0000, 1'b0, '0},
        '{32'h7FFF_FFFF, 16'h00FF, 1'b0, '0},
        '{32'h0000_0000, 16'hFFFF, 1'b0, '0},
        '{32'hFFFF_FFFE, 16'h8000, 1'b0, '0},
        '{32'hFFFF_FFFF, 16'h7FFF, 1'b0, '0},
        '{32'hFFFF_FFFF, 16'h0001, 1'b0, '0},
        '{32'h5555_5555, 16'h5A5A, 1'b0, '0}
    };

    latency_stats_top_k #(
        .TOP_K    (DEF_TOP_K),
        .TAG_BITS (DEF_TAG_BITS)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // running count, total, mean and ranking after one sample
    function automatic stats_t update_stats(input logic [TIME_W-1:0] t,
                                            input logic [TAG_IN_W-1:0] tag);
        stats_t             s;
        logic [TOTAL_W-1:0] quotient;
        logic [31:0]        tag_keep;
        logic [TIME_W-1:0]  out_time [OUT_RANKS];
        logic [TAG_IN_W-1:0] out_tag [OUT_RANKS];
        int                 slot;
        tag_keep = (DEF_TAG_BITS >= 32) ? 32'hFFFF_FFFF
                                        : ((32'd1 << DEF_TAG_BITS) - 32'd1);
        if (seen_count != '1)
            seen_count = seen_count + 1'b1;
        if (time_sum > ('1 - {32'd0, t}))
            time_sum = '1;
        else
            time_sum = time_sum + {32'd0, t};
        quotient = time_sum / {32'd0, seen_count};
        if (quotient > 64'h0000_0000_FFFF_FFFF)
            quotient = 64'h0000_0000_FFFF_FFFF;
        if (t > kept_time[DEF_TOP_K-1])
        begin
            slot = 0;
            while (!(t > kept_time[slot]))
                slot++;
            for (int i = DEF_TOP_K - 1; i > slot; i--)
            begin
                kept_time[i] = kept_time[i-1];
                kept_tag[i]  = kept_tag[i-1];
            end
            kept_time[slot] = t;
            kept_tag[slot]  = {16'd0, tag} & tag_keep;
        end
        for (int r = 0; r < OUT_RANKS; r++)
        begin
            if (r < DEF_TOP_K)
            begin
                out_time[r] = kept_time[r];
                out_tag[r]  = kept_tag[r][TAG_IN_W-1:0];
            end
            else
            begin
                out_time[r] = '0;
                out_tag[r]  = '0;
            end
        end
        s.sample_count = seen_count;
        s.time_total   = time_sum;
        s.mean_time    = quotient[TIME_W-1:0];
        s.rank0_time   = out_time[0];
        s.rank1_time   = out_time[1];
        s.rank2_time   = out_time[2];
        s.rank0_tag    = out_tag[0];
        s.rank1_tag    = out_tag[1];
        s.rank2_tag    = out_tag[2];
        return s;
    endfunction

    // mostly values that hit the ranking: ties, near the top, just above the last rank
    function automatic logic [TIME_W-1:0] pick_time();
        logic [TIME_W-1:0] pivot;
        pivot = kept_time[$urandom_range(0, DEF_TOP_K - 1)];
        case ($urandom_range(0, 9))
            0: return '0;
            1: return $urandom_range(0, 255);
            2: return 32'hFFFF_FFFF - $urandom_range(0, 255);
            3: return pivot;
            4: return pivot + $urandom_range(0, 3);
            5: return kept_time[DEF_TOP_K-1] + 1'b1;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [TAG_IN_W-1:0] pick_tag();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < MAX_PRINTS)
            $display("%0t ns: %s got %h, expected %h", $time, field, got, want);
        mismatch_count++;
    endtask

    task automatic check_field(input string field, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch(field, got, want);
    endtask

    // called at a falling edge; returns at a falling edge after the item is taken
    task automatic send_sample(input logic [TIME_W-1:0] t, input logic [TAG_IN_W-1:0] tag,
                               input bit typed, input stats_t want);
        stats_t predicted;
        int     gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sample_in_t'{source_tag: tag, sample_time: t};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = update_stats(t, tag);
        expected_stats.push_back(typed ? want : predicted);
        @(negedge clk);
        if (burst_left != 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 5);
            case (idle_mode)
                IDLE_NONE:  gap = 0;
                IDLE_LIGHT: gap = $urandom_range(0, 8);
                default:    gap = $urandom_range(0, 90);
            endcase
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    always @(negedge clk)
    begin
        if (ready_hold != 0)
            ready_hold <= ready_hold - 1;
        else
        begin
            case (idle_mode)
                IDLE_NONE:
                begin
                    m_axis_tready <= 1'b1;
                    ready_hold    <= 0;
                end
                IDLE_LIGHT:
                begin
                    m_axis_tready <= ($urandom_range(0, 3) != 0);
                    ready_hold    <= $urandom_range(0, 10);
                end
                default:
                begin
                    if (m_axis_tready)
                    begin
                        m_axis_tready <= 1'b0;
                        ready_hold    <= $urandom_range(0, 70);
                    end
                    else
                    begin
                        m_axis_tready <= 1'b1;
                        ready_hold    <= $urandom_range(0, 30);
                    end
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        stats_t got;
        stats_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (expected_stats.size() == 0)
                report_mismatch("item with nothing expected, count", got.sample_count, '0);
            else
            begin
                want = expected_stats.pop_front();
                check_field("sample_count", got.sample_count, want.sample_count);
                check_field("time_total", got.time_total, want.time_total);
                check_field("mean_time", got.mean_time, want.mean_time);
                check_field("rank0_time", got.rank0_time, want.rank0_time);
                check_field("rank1_time", got.rank1_time, want.rank1_time);
                check_field("rank2_time", got.rank2_time, want.rank2_time);
                check_field("rank0_tag", got.rank0_tag, want.rank0_tag);
                check_field("rank1_tag", got.rank1_tag, want.rank1_tag);
                check_field("rank2_tag", got.rank2_tag, want.rank2_tag);
            end
        end
    end

    initial
    begin
        for (int i = 0; i < DEF_TOP_K; i++)
        begin
            kept_time[i] = '0;
            kept_tag[i]  = '0;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < NUM_PROBES; i++)
            send_sample(probe_rows[i].sample_time, probe_rows[i].source_tag,
                        probe_rows[i].typed, probe_rows[i].want);

        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            idle_mode = idle_mode_t'((n / MODE_ITEMS) % 3);
            send_sample(pick_time(), pick_tag(), 1'b0, '0);
        end

        s_axis_tvalid <= 1'b0;
        while (expected_stats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

[sim.f]
+incdir+design
design/lst_pkg.sv
design/lst_div.sv
design/lst_rank.sv
design/latency_stats_top_k.sv
verif/tb_latency_stats_top_k.sv
